FILE: rtl/tovs_pkg.sv
`timescale 1ns / 1ps

package tovs_pkg;

    localparam int NUM_SLOTS   = 32;
    localparam int SLOT_BITS   = 5;
    localparam int SLOT_IDX_W  = $clog2(NUM_SLOTS);
    localparam int FRAME_BITS  = 24;
    localparam int POS_BITS    = 24;
    localparam int OUT_BITS    = 24;
    localparam int HIST_LEN    = 4;
    localparam int HIST_IDX_W  = $clog2(HIST_LEN);
    localparam int FILL_W      = $clog2(HIST_LEN + 1);

    localparam int VEL_DIV     = 240;
    localparam int DIV_POW2    = 4;
    localparam int DIV_ODD     = VEL_DIV / (1 << DIV_POW2);
    localparam int TAP_SHIFT   = 3;

    localparam int NUM_W       = POS_BITS + 5;
    localparam int B_W         = NUM_W - DIV_POW2;
    localparam int RECIP_W     = NUM_W - 3;
    localparam int PROD_W      = B_W + RECIP_W;
    localparam int Q_W         = PROD_W - NUM_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << NUM_W) - 64'd1) / DIV_ODD);

    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    typedef logic signed [POS_BITS-1:0] t_pos;

    typedef struct packed {
        logic [SLOT_BITS-1:0]  out_slot;
        logic [FRAME_BITS-1:0] center_frame;
        t_pos                  x0;
        t_pos                  x1;
        t_pos                  x3;
        t_pos                  x4;
        t_pos                  y0;
        t_pos                  y1;
        t_pos                  y3;
        t_pos                  y4;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

FILE: rtl/tovs_front.sv
`timescale 1ns / 1ps

module tovs_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  logic [tovs_pkg::FRAME_BITS-1:0]  i_frame_number,
    input  logic [tovs_pkg::SLOT_BITS-1:0]   i_slot,
    input  tovs_pkg::t_pos                   i_pos_x,
    input  tovs_pkg::t_pos                   i_pos_y,
    output logic                             o_push,
    output tovs_pkg::t_job                   o_job
);

    logic [tovs_pkg::FRAME_BITS-1:0] r_cur_frame;
    logic [tovs_pkg::FILL_W-1:0]     r_fill [tovs_pkg::NUM_SLOTS];
    tovs_pkg::t_pos [tovs_pkg::HIST_LEN-1:0] r_hist_x [tovs_pkg::NUM_SLOTS];
    tovs_pkg::t_pos [tovs_pkg::HIST_LEN-1:0] r_hist_y [tovs_pkg::NUM_SLOTS];

    logic [tovs_pkg::FRAME_BITS-1:0] w_next_frame;
    logic                            w_cont;
    logic                            w_slot_ok;
    logic [tovs_pkg::SLOT_IDX_W-1:0] w_idx;
    logic [tovs_pkg::FILL_W-1:0]     w_fill;
    logic [tovs_pkg::FILL_W-1:0]     n_fill;
    logic                            w_hist_full;

    assign w_next_frame = r_cur_frame + tovs_pkg::FRAME_BITS'(1);
    assign w_cont       = (i_frame_number == r_cur_frame) || (i_frame_number == w_next_frame);
    assign w_slot_ok    = {1'b0, i_slot} < (tovs_pkg::SLOT_BITS + 1)'(tovs_pkg::NUM_SLOTS);
    assign w_idx        = i_slot[tovs_pkg::SLOT_IDX_W-1:0];
    assign w_fill       = w_cont ? r_fill[w_idx] : '0;
    assign n_fill       = w_fill + tovs_pkg::FILL_W'(1);
    assign w_hist_full  = w_fill == tovs_pkg::FILL_W'(tovs_pkg::HIST_LEN);

    assign o_push = i_accept && w_slot_ok && w_hist_full;

    always_comb begin
        o_job.out_slot     = i_slot;
        o_job.center_frame = i_frame_number - tovs_pkg::FRAME_BITS'(2);
        o_job.x0           = r_hist_x[w_idx][0];
        o_job.x1           = r_hist_x[w_idx][1];
        o_job.x3           = r_hist_x[w_idx][tovs_pkg::HIST_LEN-1];
        o_job.x4           = i_pos_x;
        o_job.y0           = r_hist_y[w_idx][0];
        o_job.y1           = r_hist_y[w_idx][1];
        o_job.y3           = r_hist_y[w_idx][tovs_pkg::HIST_LEN-1];
        o_job.y4           = i_pos_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_frame <= '1;
            for (int s = 0; s < tovs_pkg::NUM_SLOTS; s++) begin
                r_fill[s] <= '0;
            end
        end else if (i_accept) begin
            r_cur_frame <= i_frame_number;
            for (int s = 0; s < tovs_pkg::NUM_SLOTS; s++) begin
                if (w_slot_ok && !w_hist_full &&
                    (tovs_pkg::SLOT_IDX_W'(s) == w_idx)) begin
                    r_fill[s] <= n_fill;
                end else if (!w_cont) begin
                    r_fill[s] <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && w_slot_ok) begin
            if (w_hist_full) begin
                for (int k = 0; k < tovs_pkg::HIST_LEN - 1; k++) begin
                    r_hist_x[w_idx][k] <= r_hist_x[w_idx][k+1];
                    r_hist_y[w_idx][k] <= r_hist_y[w_idx][k+1];
                end
                r_hist_x[w_idx][tovs_pkg::HIST_LEN-1] <= i_pos_x;
                r_hist_y[w_idx][tovs_pkg::HIST_LEN-1] <= i_pos_y;
            end else begin
                r_hist_x[w_idx][w_fill[tovs_pkg::HIST_IDX_W-1:0]] <= i_pos_x;
                r_hist_y[w_idx][w_fill[tovs_pkg::HIST_IDX_W-1:0]] <= i_pos_y;
            end
        end
    end

endmodule

FILE: rtl/tovs_fifo.sv
`timescale 1ns / 1ps

module tovs_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  tovs_pkg::t_job    i_job,
    input  logic              i_pop,
    output tovs_pkg::t_job    o_job,
    output tovs_pkg::t_q_stat o_stat
);

    tovs_pkg::t_job               r_mem [tovs_pkg::Q_DEPTH];
    logic [tovs_pkg::Q_PTR_W-1:0] r_wr_ptr;
    logic [tovs_pkg::Q_PTR_W-1:0] r_rd_ptr;
    logic [tovs_pkg::Q_CNT_W-1:0] r_count;

    assign o_job        = r_mem[r_rd_ptr];
    assign o_stat.full  = r_count == tovs_pkg::Q_CNT_W'(tovs_pkg::Q_DEPTH);
    assign o_stat.empty = r_count == '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + tovs_pkg::Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + tovs_pkg::Q_PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + tovs_pkg::Q_CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - tovs_pkg::Q_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

FILE: rtl/tovs_back.sv
`timescale 1ns / 1ps

module tovs_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  tovs_pkg::t_q_stat                i_q_stat,
    input  tovs_pkg::t_job                   i_job,
    output logic                             o_pop,
    input  logic                             i_stall,
    output logic                             o_valid,
    output logic [tovs_pkg::SLOT_BITS-1:0]   o_out_slot,
    output logic [tovs_pkg::FRAME_BITS-1:0]  o_center_frame,
    output logic signed [tovs_pkg::OUT_BITS-1:0] o_vel_x,
    output logic signed [tovs_pkg::OUT_BITS-1:0] o_vel_y
);

    localparam int SAT_W = ((tovs_pkg::Q_W > tovs_pkg::OUT_BITS) ?
                            tovs_pkg::Q_W : tovs_pkg::OUT_BITS) + 1;

    function automatic logic signed [tovs_pkg::NUM_W-1:0] f_num(
        input tovs_pkg::t_pos a0,
        input tovs_pkg::t_pos a1,
        input tovs_pkg::t_pos a3,
        input tovs_pkg::t_pos a4
    );
        logic signed [tovs_pkg::NUM_W-1:0] e0;
        logic signed [tovs_pkg::NUM_W-1:0] e1;
        logic signed [tovs_pkg::NUM_W-1:0] e3;
        logic signed [tovs_pkg::NUM_W-1:0] e4;
        e0 = tovs_pkg::NUM_W'(a0);
        e1 = tovs_pkg::NUM_W'(a1);
        e3 = tovs_pkg::NUM_W'(a3);
        e4 = tovs_pkg::NUM_W'(a4);
        return e0 - (e1 <<< tovs_pkg::TAP_SHIFT) + (e3 <<< tovs_pkg::TAP_SHIFT) - e4;
    endfunction

    logic                                   w_adv;
    logic                                   r_v1;
    logic                                   r_v2;
    logic                                   r_v3;

    logic [tovs_pkg::SLOT_BITS-1:0]         r_s1_slot;
    logic [tovs_pkg::FRAME_BITS-1:0]        r_s1_frame;
    logic signed [tovs_pkg::NUM_W-1:0]      r_s1_num [2];

    logic [tovs_pkg::SLOT_BITS-1:0]         r_s2_slot;
    logic [tovs_pkg::FRAME_BITS-1:0]        r_s2_frame;
    logic                                   r_s2_neg [2];
    logic [tovs_pkg::B_W-1:0]               r_s2_b [2];
    logic [tovs_pkg::PROD_W-1:0]            r_s2_prod [2];

    logic [tovs_pkg::NUM_W-1:0]             w_mag [2];
    logic [tovs_pkg::B_W-1:0]               w_b [2];
    logic [tovs_pkg::Q_W-1:0]               w_q0 [2];
    logic [tovs_pkg::B_W-1:0]               w_rem [2];
    logic [tovs_pkg::Q_W-1:0]               w_q [2];
    logic [SAT_W-1:0]                       w_qe [2];
    logic [SAT_W-1:0]                       w_lim [2];
    logic [SAT_W-1:0]                       w_qs [2];
    logic [SAT_W-1:0]                       w_sv [2];

    assign w_adv = !r_v3 || !i_stall;
    assign o_pop = w_adv && !i_q_stat.empty;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_mag[l] = r_s1_num[l][tovs_pkg::NUM_W-1] ? tovs_pkg::NUM_W'(-r_s1_num[l])
                                                      : tovs_pkg::NUM_W'(r_s1_num[l]);
            w_b[l]   = w_mag[l][tovs_pkg::NUM_W-1:tovs_pkg::DIV_POW2];

            w_q0[l]  = r_s2_prod[l][tovs_pkg::PROD_W-1:tovs_pkg::NUM_W];
            w_rem[l] = r_s2_b[l] - tovs_pkg::B_W'(tovs_pkg::B_W'(w_q0[l]) *
                                                  tovs_pkg::B_W'(tovs_pkg::DIV_ODD));
            w_q[l]   = (w_rem[l] >= tovs_pkg::B_W'(tovs_pkg::DIV_ODD)) ?
                       w_q0[l] + tovs_pkg::Q_W'(1) : w_q0[l];
            w_qe[l]  = SAT_W'(w_q[l]);
            w_lim[l] = r_s2_neg[l] ? (SAT_W'(1) << (tovs_pkg::OUT_BITS - 1))
                                   : (SAT_W'(1) << (tovs_pkg::OUT_BITS - 1)) - SAT_W'(1);
            w_qs[l]  = (w_qe[l] > w_lim[l]) ? w_lim[l] : w_qe[l];
            w_sv[l]  = r_s2_neg[l] ? SAT_W'(-w_qs[l]) : w_qs[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= o_pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_slot      <= i_job.out_slot;
            r_s1_frame     <= i_job.center_frame;
            r_s1_num[0]    <= f_num(i_job.x0, i_job.x1, i_job.x3, i_job.x4);
            r_s1_num[1]    <= f_num(i_job.y0, i_job.y1, i_job.y3, i_job.y4);

            r_s2_slot      <= r_s1_slot;
            r_s2_frame     <= r_s1_frame;
            for (int l = 0; l < 2; l++) begin
                r_s2_neg[l]  <= r_s1_num[l][tovs_pkg::NUM_W-1];
                r_s2_b[l]    <= w_b[l];
                r_s2_prod[l] <= tovs_pkg::PROD_W'(w_b[l]) * tovs_pkg::PROD_W'(tovs_pkg::RECIP);
            end

            o_out_slot     <= r_s2_slot;
            o_center_frame <= r_s2_frame;
            o_vel_x        <= w_sv[0][tovs_pkg::OUT_BITS-1:0];
            o_vel_y        <= w_sv[1][tovs_pkg::OUT_BITS-1:0];
        end
    end

    assign o_valid = r_v3;

endmodule

FILE: rtl/tracked_object_velocity_stencil.sv
`timescale 1ns / 1ps
// Five-point velocity of tracked objects.
// Input channel: i_valid / o_stall carry one sample per item (frame number, slot, x, y).
// An item is taken at a clock edge with i_valid high and o_stall low.
// Output channel: o_valid / i_stall carry one velocity result per item that completes a
// five-sample window in its slot; other items give no result.
// Velocity is (p0 - 8*p1 + 8*p3 - p4) / 240 per axis, truncated toward zero, tagged with
// the input frame minus two.
// Throughput: one item per cycle while o_stall is low; the front end updates a slot's history
// as each item is taken. Each completing item is written to the queue at the edge that takes it,
// then passes the stencil sum, reciprocal multiply and correction into the output register.
// A 4-entry queue sits between the front end and the arithmetic pipeline. When the receiver
// stalls, the pipeline holds its result and the queue fills; o_stall rises only once the
// queue is full.
// Reset (synchronous, active low) empties the queue and pipeline, clears all fill counts and
// sets the current frame to all ones so that frame 0 counts as a continuation.
module tracked_object_velocity_stencil (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [tovs_pkg::FRAME_BITS-1:0]      i_frame_number,
    input  logic [tovs_pkg::SLOT_BITS-1:0]       i_slot,
    input  logic signed [tovs_pkg::POS_BITS-1:0] i_pos_x,
    input  logic signed [tovs_pkg::POS_BITS-1:0] i_pos_y,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic [tovs_pkg::SLOT_BITS-1:0]       o_out_slot,
    output logic [tovs_pkg::FRAME_BITS-1:0]      o_center_frame,
    output logic signed [tovs_pkg::OUT_BITS-1:0] o_vel_x,
    output logic signed [tovs_pkg::OUT_BITS-1:0] o_vel_y
);

    logic              w_accept;
    logic              w_push;
    logic              w_pop;
    tovs_pkg::t_job    w_job_in;
    tovs_pkg::t_job    w_job_out;
    tovs_pkg::t_q_stat w_q_stat;

    assign o_stall  = w_q_stat.full;
    assign w_accept = i_valid && !o_stall;

    tovs_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_frame_number (i_frame_number),
        .i_slot         (i_slot),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .o_push         (w_push),
        .o_job          (w_job_in)
    );

    tovs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_stat  (w_q_stat)
    );

    tovs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_stat       (w_q_stat),
        .i_job          (w_job_out),
        .o_pop          (w_pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_out_slot     (o_out_slot),
        .o_center_frame (o_center_frame),
        .o_vel_x        (o_vel_x),
        .o_vel_y        (o_vel_y)
    );

`ifndef SYNTH
    a_full_not_empty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_q_stat.full |-> !w_q_stat.empty
    ) else $error("queue reports full and empty together");

    a_push_holds: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_push |=> !w_q_stat.empty
    ) else $error("queue empty right after a push");

    a_pop_needs_data: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty
    ) else $error("pop from an empty queue");
`endif

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int RANDOM_ITEMS = 850;

    typedef struct {
        logic [tovs_pkg::SLOT_BITS-1:0]  slot;
        logic [tovs_pkg::FRAME_BITS-1:0] frame;
        tovs_pkg::t_pos                  vx;
        tovs_pkg::t_pos                  vy;
    } t_velocity;

    logic                            i_clk          = 1'b0;
    logic                            i_rst_n        = 1'b0;
    logic                            i_valid        = 1'b0;
    logic                            o_stall;
    logic [tovs_pkg::FRAME_BITS-1:0] i_frame_number = '0;
    logic [tovs_pkg::SLOT_BITS-1:0]  i_slot         = '0;
    tovs_pkg::t_pos                  i_pos_x        = '0;
    tovs_pkg::t_pos                  i_pos_y        = '0;
    logic                            o_valid;
    logic                            i_stall;
    logic [tovs_pkg::SLOT_BITS-1:0]  o_out_slot;
    logic [tovs_pkg::FRAME_BITS-1:0] o_center_frame;
    logic signed [tovs_pkg::OUT_BITS-1:0] o_vel_x;
    logic signed [tovs_pkg::OUT_BITS-1:0] o_vel_y;

    logic [tovs_pkg::FILL_W-1:0]     fill_cnt [tovs_pkg::NUM_SLOTS];
    tovs_pkg::t_pos                  trail_x  [tovs_pkg::NUM_SLOTS][tovs_pkg::HIST_LEN];
    tovs_pkg::t_pos                  trail_y  [tovs_pkg::NUM_SLOTS][tovs_pkg::HIST_LEN];
    logic [tovs_pkg::FRAME_BITS-1:0] last_frame;
    t_velocity                       velocity_due [$];
    t_velocity                       head_v;

    int error_count        = 0;
    int items_sent         = 0;
    int velocities_checked = 0;
    int gap_pct            = 0;
    int stall_pct          = 0;

    always #6 i_clk = ~i_clk;

    tracked_object_velocity_stencil u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_frame_number (i_frame_number),
        .i_slot         (i_slot),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_slot     (o_out_slot),
        .o_center_frame (o_center_frame),
        .o_vel_x        (o_vel_x),
        .o_vel_y        (o_vel_y)
    );

    function automatic int pick_idle(int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic tovs_pkg::t_pos central_diff(tovs_pkg::t_pos p0, tovs_pkg::t_pos p1,
                                                     tovs_pkg::t_pos p3, tovs_pkg::t_pos p4);
        longint num;
        longint q;
        longint hi;
        hi  = (longint'(1) <<< (tovs_pkg::OUT_BITS - 1)) - 1;
        num = longint'(p0) - 8 * longint'(p1) + 8 * longint'(p3) - longint'(p4);
        q   = num / tovs_pkg::VEL_DIV;
        if (q > hi) q = hi;
        if (q < -hi - 1) q = -hi - 1;
        return tovs_pkg::t_pos'(q);
    endfunction

    function automatic void track_sample(logic [tovs_pkg::FRAME_BITS-1:0] frame,
                                         logic [tovs_pkg::SLOT_BITS-1:0] slot,
                                         tovs_pkg::t_pos x, tovs_pkg::t_pos y);
        t_velocity                       v;
        logic [tovs_pkg::FRAME_BITS-1:0] next_frame;
        logic [tovs_pkg::HIST_IDX_W-1:0] fill_idx;
        next_frame = last_frame + tovs_pkg::FRAME_BITS'(1);
        if (frame != last_frame && frame != next_frame) begin
            for (int s = 0; s < tovs_pkg::NUM_SLOTS; s++) fill_cnt[s] = '0;
        end
        last_frame = frame;
        if (int'(slot) >= tovs_pkg::NUM_SLOTS) return;
        if (fill_cnt[slot] >= tovs_pkg::HIST_LEN) begin
            v.slot  = slot;
            v.frame = frame - tovs_pkg::FRAME_BITS'(2);
            v.vx    = central_diff(trail_x[slot][0], trail_x[slot][1], trail_x[slot][3], x);
            v.vy    = central_diff(trail_y[slot][0], trail_y[slot][1], trail_y[slot][3], y);
            velocity_due = {velocity_due, v};
            for (int k = 0; k < tovs_pkg::HIST_LEN - 1; k++) begin
                trail_x[slot][k] = trail_x[slot][k + 1];
                trail_y[slot][k] = trail_y[slot][k + 1];
            end
            trail_x[slot][tovs_pkg::HIST_LEN - 1] = x;
            trail_y[slot][tovs_pkg::HIST_LEN - 1] = y;
        end else begin
            fill_idx = tovs_pkg::HIST_IDX_W'(fill_cnt[slot]);
            trail_x[slot][fill_idx] = x;
            trail_y[slot][fill_idx] = y;
            fill_cnt[slot]++;
        end
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        error_count++;
        $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want,
                 velocities_checked);
    endtask

    task automatic send_sample(logic [tovs_pkg::FRAME_BITS-1:0] frame,
                               logic [tovs_pkg::SLOT_BITS-1:0] slot,
                               tovs_pkg::t_pos x, tovs_pkg::t_pos y);
        int gap;
        gap = pick_idle(gap_pct);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_frame_number <= frame;
        i_slot         <= slot;
        i_pos_x        <= x;
        i_pos_y        <= y;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        track_sample(frame, slot, x, y);
        items_sent++;
    endtask

    // check each accepted result against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (velocity_due.size() == 0) begin
                report_mismatch("unexpected result slot", o_out_slot, 0);
            end else begin
                head_v = velocity_due.pop_front();
                if (o_out_slot !== head_v.slot)
                    report_mismatch("out_slot", o_out_slot, head_v.slot);
                if (o_center_frame !== head_v.frame)
                    report_mismatch("center_frame", o_center_frame, head_v.frame);
                if (o_vel_x !== head_v.vx)
                    report_mismatch("vel_x", o_vel_x, head_v.vx);
                if (o_vel_y !== head_v.vy)
                    report_mismatch("vel_y", o_vel_y, head_v.vy);
                velocities_checked++;
            end
        end
    end

    initial begin
        int hold;
        hold    = 0;
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
                i_stall <= 1'b1;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                hold = pick_idle(100) - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    task automatic test_first_window;
        gap_pct   = 0;
        stall_pct = 0;
        for (int f = 0; f < 5; f++)
            send_sample(tovs_pkg::FRAME_BITS'(f), 5'd0, tovs_pkg::t_pos'(f * 768),
                        tovs_pkg::t_pos'(-f * 100));
    endtask

    task automatic test_frame_wrap;
        logic [tovs_pkg::FRAME_BITS-1:0] frame;
        gap_pct   = 20;
        stall_pct = 20;
        frame = 24'hFFFFFD;
        for (int k = 0; k < 5; k++) begin
            send_sample(frame, 5'd1, tovs_pkg::t_pos'($urandom), tovs_pkg::t_pos'($urandom));
            frame = frame + tovs_pkg::FRAME_BITS'(1);
        end
    endtask

    task automatic test_position_extremes;
        tovs_pkg::t_pos pmax;
        tovs_pkg::t_pos pmin;
        tovs_pkg::t_pos seq [8];
        pmax = {1'b0, {(tovs_pkg::POS_BITS - 1){1'b1}}};
        pmin = {1'b1, {(tovs_pkg::POS_BITS - 1){1'b0}}};
        seq  = '{pmax, pmin, '0, pmax, pmin, pmax, pmin, pmax};
        gap_pct   = 50;
        stall_pct = 50;
        for (int k = 0; k < 8; k++)
            send_sample(24'h000123, 5'd31, seq[k], seq[7 - k]);
    endtask

    task automatic test_jump_clears;
        gap_pct   = 10;
        stall_pct = 60;
        for (int k = 0; k < 4; k++)
            send_sample(tovs_pkg::FRAME_BITS'(10 + k), 5'd5, tovs_pkg::t_pos'(k * 4096),
                        tovs_pkg::t_pos'(k * -512));
        send_sample(24'd20, 5'd5, tovs_pkg::t_pos'(-7), tovs_pkg::t_pos'(9));
        send_sample(24'd21, 5'd5, tovs_pkg::t_pos'(300), tovs_pkg::t_pos'(-300));
        send_sample(24'd21, 5'd5, tovs_pkg::t_pos'(1200), tovs_pkg::t_pos'(-1100));
        send_sample(24'd22, 5'd5, tovs_pkg::t_pos'(2700), tovs_pkg::t_pos'(-2500));
        send_sample(24'd22, 5'd5, tovs_pkg::t_pos'(4800), tovs_pkg::t_pos'(-4000));
    endtask

    task automatic test_random_streams;
        logic [tovs_pkg::FRAME_BITS-1:0] frame;
        logic [tovs_pkg::SLOT_BITS-1:0]  pool [6];
        tovs_pkg::t_pos                  px [6];
        tovs_pkg::t_pos                  py [6];
        int                              start_items;
        int                              npool;
        int                              run_len;
        int                              pick;
        bit                              smooth;
        bit                              quiet;
        start_items = items_sent;
        frame = '1;
        while (items_sent - start_items < RANDOM_ITEMS) begin
            quiet     = ($urandom_range(0, 3) == 0);
            gap_pct   = quiet ? 0 : $urandom_range(5, 40);
            stall_pct = quiet ? 0 : $urandom_range(5, 50);
            if ($urandom_range(0, 99) < 85) begin
                if ($urandom_range(0, 4) == 0)
                    frame = 24'hFFFFFF - tovs_pkg::FRAME_BITS'($urandom_range(0, 20));
                else if ($urandom_range(0, 1) == 0)
                    frame = tovs_pkg::FRAME_BITS'($urandom);
                npool   = $urandom_range(1, 6);
                run_len = $urandom_range(15, 60);
                smooth  = $urandom_range(0, 1);
                for (int i = 0; i < npool; i++) begin
                    pool[i] = tovs_pkg::SLOT_BITS'($urandom_range(0, tovs_pkg::NUM_SLOTS - 1));
                    px[i]   = tovs_pkg::t_pos'($urandom);
                    py[i]   = tovs_pkg::t_pos'($urandom);
                end
                for (int n = 0; n < run_len; n++) begin
                    pick = $urandom_range(0, npool - 1);
                    if ($urandom_range(0, 99) < 30) frame = frame + tovs_pkg::FRAME_BITS'(1);
                    if (smooth) begin
                        px[pick] = px[pick] +
                                   tovs_pkg::t_pos'(int'($urandom_range(0, 2047)) - 1024);
                        py[pick] = py[pick] +
                                   tovs_pkg::t_pos'(int'($urandom_range(0, 2047)) - 1024);
                    end else begin
                        px[pick] = tovs_pkg::t_pos'($urandom);
                        py[pick] = tovs_pkg::t_pos'($urandom);
                    end
                    send_sample(frame, pool[pick], px[pick], py[pick]);
                end
            end else begin
                run_len = $urandom_range(1, 8);
                for (int n = 0; n < run_len; n++) begin
                    if ($urandom_range(0, 2) == 0)
                        frame = frame + tovs_pkg::FRAME_BITS'(2);
                    else
                        frame = tovs_pkg::FRAME_BITS'($urandom);
                    send_sample(frame, tovs_pkg::SLOT_BITS'($urandom),
                                tovs_pkg::t_pos'($urandom), tovs_pkg::t_pos'($urandom));
                end
            end
        end
    endtask

    initial begin
        for (int s = 0; s < tovs_pkg::NUM_SLOTS; s++) fill_cnt[s] = '0;
        last_frame = '1;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_first_window();
        test_frame_wrap();
        test_position_extremes();
        test_jump_clears();
        test_random_streams();

        i_valid <= 1'b0;
        while (velocity_due.size() != 0) @(posedge i_clk);
        stall_pct = 0;
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: tracked_object_velocity_stencil.f
rtl/tovs_pkg.sv
rtl/tovs_front.sv
rtl/tovs_fifo.sv
rtl/tovs_back.sv
rtl/tracked_object_velocity_stencil.sv
bench/tb.sv
